// ===== rtl/iawf_pkg.sv =====
// ----------------------------------------------------------------------------
// iawf_pkg
// Shared types, codes and widths for the integer alu with flags.
// ----------------------------------------------------------------------------
`default_nettype none

package iawf_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned IN_W    = 160;
  localparam int unsigned OUT_W   = 72;

  typedef enum logic [4:0] {
    FN_AND    = 5'd0,
    FN_BIC    = 5'd1,
    FN_ORR    = 5'd2,
    FN_ORN    = 5'd3,
    FN_EOR    = 5'd4,
    FN_EON    = 5'd5,
    FN_ADDSH  = 5'd6,
    FN_SUBSH  = 5'd7,
    FN_ADDEXT = 5'd8,
    FN_SUBEXT = 5'd9,
    FN_ADC    = 5'd10,
    FN_SBC    = 5'd11,
    FN_CCMN   = 5'd12,
    FN_CCMP   = 5'd13,
    FN_CSEL   = 5'd14,
    FN_CSINC  = 5'd15,
    FN_CSINV  = 5'd16,
    FN_CSNEG  = 5'd17
  } func_t;

  // shift kinds
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // extend sizes (low two bits of extend_kind)
  localparam logic [1:0] EXT_B = 2'd0;
  localparam logic [1:0] EXT_H = 2'd1;
  localparam logic [1:0] EXT_W = 2'd2;
  localparam logic [1:0] EXT_X = 2'd3;

  // condition bases (condition code without its invert bit)
  localparam logic [2:0] CB_EQ = 3'd0;
  localparam logic [2:0] CB_CS = 3'd1;
  localparam logic [2:0] CB_MI = 3'd2;
  localparam logic [2:0] CB_VS = 3'd3;
  localparam logic [2:0] CB_HI = 3'd4;
  localparam logic [2:0] CB_GE = 3'd5;
  localparam logic [2:0] CB_GT = 3'd6;
  localparam logic [3:0] COND_NV = 4'd15;

  typedef struct packed {
    logic [4:0]        func;
    logic              is_64;
    logic              set_flags;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [1:0]        shift_kind;
    logic [5:0]        shift_amount;
    logic [2:0]        extend_kind;
    logic [2:0]        extend_shift;
    logic [3:0]        condition;
    logic [3:0]        nzcv_immediate;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result;
    logic               result_valid;
    logic [FLAGS_W-1:0] flags;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/iawf_operand.sv =====
// ----------------------------------------------------------------------------
// iawf_operand
// Second operand preparation: barrel shift and extend-then-shift forms.
// ----------------------------------------------------------------------------
`default_nettype none

module iawf_operand
  import iawf_pkg::*;
(
  input  wire logic [DATA_W-1:0] operand_b,
  input  wire logic              is_64,
  input  wire logic [1:0]        shift_kind,
  input  wire logic [5:0]        shift_amount,
  input  wire logic [2:0]        extend_kind,
  input  wire logic [2:0]        extend_shift,
  output logic      [DATA_W-1:0] shifted,
  output logic      [DATA_W-1:0] extended
);

  logic [HALF_W-1:0]   v32;
  logic [4:0]          amt32;
  logic [HALF_W-1:0]   r32;
  logic [DATA_W-1:0]   r64;
  logic [2*HALF_W-1:0] rot32;
  logic [2*DATA_W-1:0] rot64;
  logic [DATA_W-1:0]   ext;

  // 32-bit and 64-bit shifters side by side, width picks one
  always_comb begin
    v32   = operand_b[HALF_W-1:0];
    amt32 = shift_amount[4:0];
    rot32 = {v32, v32} >> amt32;
    rot64 = {operand_b, operand_b} >> shift_amount;
    case (shift_kind)
      SH_LSL: begin
        r32 = v32 << amt32;
        r64 = operand_b << shift_amount;
      end
      SH_LSR: begin
        r32 = v32 >> amt32;
        r64 = operand_b >> shift_amount;
      end
      SH_ASR: begin
        r32 = HALF_W'($signed(v32) >>> amt32);
        r64 = DATA_W'($signed(operand_b) >>> shift_amount);
      end
      default: begin
        r32 = rot32[HALF_W-1:0];
        r64 = rot64[DATA_W-1:0];
      end
    endcase
    shifted = is_64 ? r64 : {{(DATA_W-HALF_W){1'b0}}, r32};
  end

  always_comb begin
    case (extend_kind[1:0])
      EXT_B:   ext = extend_kind[2] ? {{(DATA_W-8){operand_b[7]}}, operand_b[7:0]}
                                    : {{(DATA_W-8){1'b0}}, operand_b[7:0]};
      EXT_H:   ext = extend_kind[2] ? {{(DATA_W-16){operand_b[15]}}, operand_b[15:0]}
                                    : {{(DATA_W-16){1'b0}}, operand_b[15:0]};
      EXT_W:   ext = extend_kind[2] ? {{(DATA_W-32){operand_b[31]}}, operand_b[31:0]}
                                    : {{(DATA_W-32){1'b0}}, operand_b[31:0]};
      default: ext = operand_b;
    endcase
    extended = ext << extend_shift;
  end

endmodule

`default_nettype wire

// ===== rtl/iawf_exec.sv =====
// ----------------------------------------------------------------------------
// iawf_exec
// Execute logic: adder with flags, logical unit, condition test and selects.
// ----------------------------------------------------------------------------
`default_nettype none

module iawf_exec
  import iawf_pkg::*;
(
  input  wire item_t               item,
  input  wire logic [FLAGS_W-1:0]  flags,
  input  wire logic [DATA_W-1:0]   shifted,
  input  wire logic [DATA_W-1:0]   extended,
  output res_t                     res
);

  function automatic logic cond_holds(input logic [3:0] cond, input logic [FLAGS_W-1:0] fl);
    logic n, z, c, v, r;
    n = fl[3];
    z = fl[2];
    c = fl[1];
    v = fl[0];
    case (cond[3:1])
      CB_EQ:   r = z;
      CB_CS:   r = c;
      CB_MI:   r = n;
      CB_VS:   r = v;
      CB_HI:   r = c && !z;
      CB_GE:   r = (n == v);
      CB_GT:   r = (n == v) && !z;
      default: r = 1'b1;
    endcase
    if (cond[0] && cond != COND_NV) begin
      r = !r;
    end
    return r;
  endfunction

  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] b_sel;
  logic [DATA_W-1:0] op2;
  logic [DATA_W-1:0] a_m;
  logic [DATA_W-1:0] op2_m;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] add_res;
  logic [DATA_W-1:0] ov_vec;
  logic              is_sub;
  logic              cin;
  logic              carry;
  logic              ovf;
  logic [3:0]        add_flags;
  logic [DATA_W-1:0] lop;
  logic [DATA_W-1:0] log_res;
  logic [3:0]        log_flags;
  logic              cond_ok;
  logic [DATA_W-1:0] alt;
  logic [DATA_W-1:0] sel_res;
  func_t             fn;

  always_comb begin
    fn = func_t'(item.func);
    m  = item.is_64 ? {DATA_W{1'b1}} : {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};

    // shared adder: add/sub forms, carry forms and conditional compares
    case (fn)
      FN_ADDSH, FN_SUBSH:   b_sel = shifted;
      FN_ADDEXT, FN_SUBEXT: b_sel = extended;
      default:              b_sel = item.operand_b;
    endcase
    is_sub  = (fn == FN_SUBSH) || (fn == FN_SUBEXT) || (fn == FN_SBC) || (fn == FN_CCMP);
    cin     = ((fn == FN_ADC) || (fn == FN_SBC)) ? flags[1] : is_sub;
    op2     = is_sub ? ~b_sel : b_sel;
    a_m     = item.operand_a & m;
    op2_m   = op2 & m;
    sum     = {1'b0, a_m} + {1'b0, op2_m} + {{DATA_W{1'b0}}, cin};
    add_res = sum[DATA_W-1:0] & m;
    carry   = item.is_64 ? sum[DATA_W] : sum[HALF_W];
    ov_vec  = ~(a_m ^ op2_m) & (a_m ^ add_res);
    ovf     = item.is_64 ? ov_vec[DATA_W-1] : ov_vec[HALF_W-1];
    add_flags = {item.is_64 ? add_res[DATA_W-1] : add_res[HALF_W-1],
                 add_res == '0, carry, ovf};

    // logical unit, odd codes invert the shifted operand
    lop = item.func[0] ? ~shifted : shifted;
    case (fn)
      FN_AND, FN_BIC: log_res = item.operand_a & lop;
      FN_ORR, FN_ORN: log_res = item.operand_a | lop;
      default:        log_res = item.operand_a ^ lop;
    endcase
    log_res   = log_res & m;
    log_flags = {item.is_64 ? log_res[DATA_W-1] : log_res[HALF_W-1], log_res == '0, 2'b00};

    cond_ok = cond_holds(item.condition, flags);
    alt     = ((fn == FN_CSINV) || (fn == FN_CSNEG)) ? ~item.operand_b : item.operand_b;
    if ((fn == FN_CSINC) || (fn == FN_CSNEG)) begin
      alt = alt + {{(DATA_W-1){1'b0}}, 1'b1};
    end
    sel_res = (cond_ok ? item.operand_a : alt) & m;

    res.result       = '0;
    res.result_valid = 1'b0;
    res.flags        = flags;
    case (fn)
      FN_AND, FN_BIC: begin
        res.result       = log_res;
        res.result_valid = 1'b1;
        if (item.set_flags) begin
          res.flags = log_flags;
        end
      end
      FN_ORR, FN_ORN, FN_EOR, FN_EON: begin
        res.result       = log_res;
        res.result_valid = 1'b1;
      end
      FN_ADDSH, FN_SUBSH, FN_ADDEXT, FN_SUBEXT, FN_ADC, FN_SBC: begin
        res.result       = add_res;
        res.result_valid = 1'b1;
        if (item.set_flags) begin
          res.flags = add_flags;
        end
      end
      FN_CCMN, FN_CCMP: begin
        // failed condition loads the immediate flags
        res.flags = cond_ok ? add_flags : item.nzcv_immediate;
      end
      FN_CSEL, FN_CSINC, FN_CSINV, FN_CSNEG: begin
        res.result       = sel_res;
        res.result_valid = 1'b1;
      end
      default: begin
        res.result = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/integer_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_flags_core
// Integer data-processing unit with shifted/extended operands and NZCV flags.
// ----------------------------------------------------------------------------
// One instruction per transfer, one transfer per cycle sustained while the
// output side is not stalled. An item is captured in an input register,
// executed in a single combinational pass and moves into the result register
// when the output side can advance. The result is presented from the result
// register and transfers out when m_tready is high. The NZCV register is
// written as an item moves into the result register, so the next item sees
// the updated flags with no bubble. While a result waits, the input side
// takes at most one more transfer, into an empty input register, and then
// holds s_tready low until the result drains.
`default_nettype none

module integer_alu_with_flags_core
  import iawf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // func[4:0], is_64[5], set_flags[6], operand_a[70:7], operand_b[134:71],
  // shift_kind[136:135], shift_amount[142:137], extend_kind[145:143],
  // extend_shift[148:146], condition[152:149], nzcv_immediate[156:153]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // result[63:0], flags_out[67:64]
  output logic      [OUT_W-1:0] m_tdata,
  // result_valid[0]
  output logic                  m_tuser
);

  item_t              item;
  logic               item_valid;
  logic [FLAGS_W-1:0] nzcv_flags;
  res_t               out_res;
  res_t               exec_res;
  logic [DATA_W-1:0]  shifted;
  logic [DATA_W-1:0]  extended;
  logic               advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.func           <= s_tdata[4:0];
      item.is_64          <= s_tdata[5];
      item.set_flags      <= s_tdata[6];
      item.operand_a      <= s_tdata[70:7];
      item.operand_b      <= s_tdata[134:71];
      item.shift_kind     <= s_tdata[136:135];
      item.shift_amount   <= s_tdata[142:137];
      item.extend_kind    <= s_tdata[145:143];
      item.extend_shift   <= s_tdata[148:146];
      item.condition      <= s_tdata[152:149];
      item.nzcv_immediate <= s_tdata[156:153];
    end
  end

  iawf_operand u_operand (
    .operand_b    (item.operand_b),
    .is_64        (item.is_64),
    .shift_kind   (item.shift_kind),
    .shift_amount (item.shift_amount),
    .extend_kind  (item.extend_kind),
    .extend_shift (item.extend_shift),
    .shifted      (shifted),
    .extended     (extended)
  );

  iawf_exec u_exec (
    .item     (item),
    .flags    (nzcv_flags),
    .shifted  (shifted),
    .extended (extended),
    .res      (exec_res)
  );

  // flags commit together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      nzcv_flags <= '0;
    end else if (advance) begin
      m_tvalid <= item_valid;
      if (item_valid) begin
        nzcv_flags <= exec_res.flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_res <= exec_res;
    end
  end

  assign m_tdata = {{(OUT_W-DATA_W-FLAGS_W){1'b0}}, out_res.flags, out_res.result};
  assign m_tuser = out_res.result_valid;

endmodule

`default_nettype wire
